[rtl/core/bfsp_pkg.sv]
package bfsp_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned VALUE_W = 13;
  localparam int unsigned VC_W    = 11;
  localparam int unsigned EC_W    = 13;
  localparam int unsigned ROW_W   = 13;
  localparam int unsigned CFG_W   = 13;

  // flag memory word layout
  localparam int unsigned FLAG_VISITED  = 0;
  localparam int unsigned FLAG_FRONTIER = 1;
  localparam int unsigned FLAG_W        = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_ROW   = 2'd0,
    FUNC_LOAD_NB    = 2'd1,
    FUNC_LOAD_FLAGS = 2'd2,
    FUNC_PROCESS    = 2'd3
  } func_e;

  typedef enum logic {
    REG_VERTEX_COUNT = 1'b0,
    REG_EDGE_COUNT   = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LOAD_FLAG,
    ST_VIS,
    ST_END,
    ST_RANGE,
    ST_RANGE2,
    ST_WALK,
    ST_SRC,
    ST_HIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic               frontier_bit;
    logic               visited_bit;
  } in_word_t;

  typedef struct packed {
    logic newly_active;
    logic visited_now;
    logic status;
  } out_word_t;

  typedef struct packed {
    cfg_reg_e         index;
    logic [CFG_W-1:0] wdata;
  } cfg_word_t;

endpackage

[rtl/core/bfsp_in_if.sv]
interface bfsp_in_if;
  import bfsp_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/bfsp_out_if.sv]
interface bfsp_out_if;
  import bfsp_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/bfsp_cfg_if.sv]
interface bfsp_cfg_if;
  import bfsp_pkg::*;

  logic      valid;
  logic      ready;
  cfg_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/bfsp_ram.sv]
module bfsp_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 13,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bfs_pull_frontier_step.sv]
// load words: a row-offset load also reads back the vertex's visited flag
// process words: a bad index or vertex count gives an error status, a visited vertex is
// reported as such, else the in-neighbors are walked up to a hit or to the end of the list,
// and the last vertex skips the next row read and ends its list at the edge count
// sequential: the next word is taken in the cycle after the result register loads; one shared
// comparator and incrementer serve all steps. reset: control clears at once, then a pass zeroes the flag memory
module bfs_pull_frontier_step #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfsp_in_if.sink    in_i,
  bfsp_out_if.source out_o,
  bfsp_cfg_if.sink   cfg_i
);
  import bfsp_pkg::*;

  localparam int unsigned VW   = $clog2(MAX_VERTICES);
  localparam int unsigned EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW_V = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW_E = $clog2(MAX_EDGES + 1);
  localparam int unsigned CW_M = (CW_V > CW_E) ? CW_V : CW_E;
  localparam int unsigned CW   = (CW_M > VALUE_W) ? CW_M : VALUE_W;
  localparam logic [VW-1:0] CLR_LAST = VW'(MAX_VERTICES - 1);

  state_e state_q, state_d;

  func_e              func_q;
  logic [INDEX_W-1:0] idx_q;
  logic [VALUE_W-1:0] val_q;
  logic               fbit_q, vbit_q;

  logic [VC_W-1:0] vc_q;
  logic [EC_W-1:0] ec_q;

  logic [CW-1:0] e_q, e_d;
  logic [CW-1:0] start_q, start_d;
  logic [CW-1:0] end_q, end_d;
  logic          fr_self_q, fr_self_d;
  logic [VW-1:0] clr_q, clr_d;

  out_word_t res_q, res_d;
  out_word_t out_q;
  logic      out_valid_q;
  logic      out_load;
  logic      in_acc;

  // memory ports
  logic              row_we;
  logic [VW-1:0]     row_waddr, row_raddr;
  logic [ROW_W-1:0]  row_wdata, row_rdata;
  logic              nb_we;
  logic [EW-1:0]     nb_waddr, nb_raddr;
  logic [VW-1:0]     nb_wdata, nb_rdata;
  logic              fl_we;
  logic [VW-1:0]     fl_waddr, fl_raddr;
  logic [FLAG_W-1:0] fl_wdata, fl_rdata;

  // shared compare and increment unit
  logic [CW-1:0] cmp_a, cmp_b, inc_a, inc_y;
  logic          cmp_lt;

  logic [CW-1:0] idx_x, val_x, vc_x, ec_x, src_x;
  logic [VW-1:0] idx_va;
  logic          idx_in_v, vc_bad, end_big;

  assign idx_x    = CW'(idx_q);
  assign val_x    = CW'(val_q);
  assign vc_x     = CW'(vc_q);
  assign ec_x     = CW'(ec_q);
  assign src_x    = CW'(nb_rdata);
  assign idx_va   = idx_x[VW-1:0];
  assign idx_in_v = idx_x < CW'(MAX_VERTICES);
  assign vc_bad   = vc_x > CW'(MAX_VERTICES);
  assign end_big  = end_q > CW'(MAX_EDGES);

  bfsp_ram #(.DEPTH(MAX_VERTICES), .WIDTH(ROW_W)) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  bfsp_ram #(.DEPTH(MAX_EDGES), .WIDTH(VW)) u_nb_mem (
    .clk_i   (clk_i),
    .we_i    (nb_we),
    .waddr_i (nb_waddr),
    .wdata_i (nb_wdata),
    .raddr_i (nb_raddr),
    .rdata_o (nb_rdata)
  );

  bfsp_ram #(.DEPTH(MAX_VERTICES), .WIDTH(FLAG_W)) u_flag_mem (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  // operand selection for the shared unit
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    inc_a = idx_x;
    case (state_q)
      ST_EXEC: begin
        cmp_a = idx_x;
        cmp_b = vc_x;
      end
      ST_VIS: begin
        cmp_a = inc_y;
        cmp_b = vc_x;
      end
      ST_RANGE: begin
        cmp_a = end_q;
        cmp_b = start_q;
      end
      ST_RANGE2: begin
        cmp_a = ec_x;
        cmp_b = end_q;
      end
      ST_WALK: begin
        cmp_a = e_q;
        cmp_b = end_q;
      end
      ST_SRC: begin
        cmp_a = src_x;
        cmp_b = vc_x;
        inc_a = e_q;
      end
      default: begin
        cmp_a = '0;
      end
    endcase
  end

  assign cmp_lt = cmp_a < cmp_b;
  assign inc_y  = inc_a + CW'(1);

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    e_d       = e_q;
    start_d   = start_q;
    end_d     = end_q;
    fr_self_d = fr_self_q;
    clr_d     = clr_q;
    res_d     = res_q;

    row_we    = 1'b0;
    row_waddr = idx_va;
    row_wdata = val_q;
    row_raddr = idx_va;
    nb_we     = 1'b0;
    nb_waddr  = idx_x[EW-1:0];
    nb_wdata  = val_x[VW-1:0];
    nb_raddr  = e_q[EW-1:0];
    fl_we     = 1'b0;
    fl_waddr  = idx_va;
    fl_wdata  = {fbit_q, vbit_q};
    fl_raddr  = idx_va;

    case (state_q)
      ST_CLEAR: begin
        fl_we    = 1'b1;
        fl_waddr = clr_q;
        fl_wdata = '0;
        clr_d    = clr_q + VW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = '{newly_active: 1'b0, visited_now: 1'b0, status: 1'b1};
        state_d = ST_DONE;
        case (func_q)
          FUNC_LOAD_ROW: begin
            if (idx_in_v) begin
              row_we  = 1'b1;
              state_d = ST_LOAD_FLAG;
            end
          end
          FUNC_LOAD_NB: begin
            if ((idx_x < CW'(MAX_EDGES)) && (val_x < CW'(MAX_VERTICES))) begin
              nb_we = 1'b1;
              res_d = '{newly_active: 1'b0, visited_now: 1'b0, status: 1'b0};
            end
          end
          FUNC_LOAD_FLAGS: begin
            if (idx_in_v) begin
              fl_we = 1'b1;
              res_d = '{newly_active: 1'b0, visited_now: vbit_q, status: 1'b0};
            end
          end
          FUNC_PROCESS: begin
            if (!vc_bad && cmp_lt) begin
              state_d = ST_VIS;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_LOAD_FLAG: begin
        res_d   = '{newly_active: 1'b0, visited_now: fl_rdata[FLAG_VISITED], status: 1'b0};
        state_d = ST_DONE;
      end
      ST_VIS: begin
        if (fl_rdata[FLAG_VISITED]) begin
          res_d   = '{newly_active: 1'b0, visited_now: 1'b1, status: 1'b0};
          state_d = ST_DONE;
        end else begin
          fr_self_d = fl_rdata[FLAG_FRONTIER];
          start_d   = CW'(row_rdata);
          if (cmp_lt) begin
            // not the last vertex: end offset is the next row entry
            row_raddr = inc_y[VW-1:0];
            state_d   = ST_END;
          end else begin
            end_d   = ec_x;
            state_d = ST_RANGE;
          end
        end
      end
      ST_END: begin
        end_d   = CW'(row_rdata);
        state_d = ST_RANGE;
      end
      ST_RANGE: begin
        if (cmp_lt) begin
          res_d   = '{newly_active: 1'b0, visited_now: 1'b0, status: 1'b1};
          state_d = ST_DONE;
        end else begin
          state_d = ST_RANGE2;
        end
      end
      ST_RANGE2: begin
        if (cmp_lt || end_big) begin
          res_d   = '{newly_active: 1'b0, visited_now: 1'b0, status: 1'b1};
          state_d = ST_DONE;
        end else begin
          e_d     = start_q;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cmp_lt) begin
          state_d = ST_SRC;
        end else begin
          res_d   = '{newly_active: 1'b0, visited_now: 1'b0, status: 1'b0};
          state_d = ST_DONE;
        end
      end
      ST_SRC: begin
        if (!cmp_lt) begin
          res_d   = '{newly_active: 1'b0, visited_now: 1'b0, status: 1'b1};
          state_d = ST_DONE;
        end else begin
          fl_raddr = nb_rdata;
          e_d      = inc_y;
          state_d  = ST_HIT;
        end
      end
      ST_HIT: begin
        if (fl_rdata[FLAG_FRONTIER]) begin
          fl_we    = 1'b1;
          fl_wdata = {fr_self_q, 1'b1};
          res_d    = '{newly_active: 1'b1, visited_now: 1'b1, status: 1'b0};
          state_d  = ST_DONE;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q       <= e_d;
    start_q   <= start_d;
    end_q     <= end_d;
    fr_self_q <= fr_self_d;
    res_q     <= res_d;
    if (in_acc) begin
      func_q <= in_i.data.func;
      idx_q  <= in_i.data.index;
      val_q  <= in_i.data.value;
      fbit_q <= in_i.data.frontier_bit;
      vbit_q <= in_i.data.visited_bit;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // config registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= '0;
      ec_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        REG_VERTEX_COUNT: vc_q <= cfg_i.data.wdata[VC_W-1:0];
        REG_EDGE_COUNT:   ec_q <= cfg_i.data.wdata[EC_W-1:0];
        default:          vc_q <= vc_q;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EXEC))
    else $error("accepted word did not start execution");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> !(end_q < e_q))
    else $error("edge walk ran past its end offset");

  a_active_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.newly_active) |->
      (out_o.data.visited_now && !out_o.data.status))
    else $error("newly active vertex not reported visited and ok");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result word raised outside the done state");

endmodule

[sim/bfsp_checker.sv]
`timescale 1ns / 1ps

module bfsp_checker #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  bfsp_in_if   in_mon,
  bfsp_out_if  out_mon,
  bfsp_cfg_if  cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import bfsp_pkg::*;

  localparam int unsigned NB_W = $clog2(MAX_VERTICES);

  logic [ROW_W-1:0] offset_mem   [MAX_VERTICES];
  logic [NB_W-1:0]  nbr_mem      [MAX_EDGES];
  bit               frontier_mem [MAX_VERTICES];
  bit               visited_mem  [MAX_VERTICES];
  logic [VC_W-1:0]  vertex_cnt;
  logic [EC_W-1:0]  edge_cnt;
  out_word_t        expected_results [$];
  int               mismatches = 0;

  assign fail_count_o = mismatches;

  // one bottom-up step for a single word, updating the mirrored tables
  function automatic out_word_t pull_step(in_word_t w);
    out_word_t   res;
    int unsigned idx, vc, ec, lo, hi, e, src;
    res = '0;
    idx = w.index;
    vc  = vertex_cnt;
    ec  = edge_cnt;
    case (w.func)
      FUNC_LOAD_ROW: begin
        if (idx >= MAX_VERTICES) begin
          res.status = 1'b1;
        end else begin
          offset_mem[idx] = w.value;
          res.visited_now = visited_mem[idx];
        end
      end
      FUNC_LOAD_NB: begin
        if (idx >= MAX_EDGES || w.value >= MAX_VERTICES) begin
          res.status = 1'b1;
        end else begin
          nbr_mem[idx] = w.value[NB_W-1:0];
        end
      end
      FUNC_LOAD_FLAGS: begin
        if (idx >= MAX_VERTICES) begin
          res.status = 1'b1;
        end else begin
          frontier_mem[idx] = w.frontier_bit;
          visited_mem[idx]  = w.visited_bit;
          res.visited_now   = w.visited_bit;
        end
      end
      FUNC_PROCESS: begin
        if (vc > MAX_VERTICES || idx >= vc) begin
          res.status = 1'b1;
          return res;
        end
        if (visited_mem[idx]) begin
          res.visited_now = 1'b1;
          return res;
        end
        lo = offset_mem[idx];
        // the last vertex ends at the edge count
        hi = (idx + 1 < vc) ? offset_mem[idx + 1] : ec;
        if (lo > hi || hi > ec || hi > MAX_EDGES) begin
          res.status = 1'b1;
          return res;
        end
        for (e = lo; e < hi; e++) begin
          src = nbr_mem[e];
          if (src >= vc) begin
            res.status = 1'b1;
            return res;
          end
          if (frontier_mem[src]) begin
            visited_mem[idx]  = 1'b1;
            res.newly_active  = 1'b1;
            res.visited_now   = 1'b1;
            return res;
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
        frontier_mem[v] = 1'b0;
        visited_mem[v]  = 1'b0;
      end
      vertex_cnt = '0;
      edge_cnt   = '0;
      expected_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.data.index == REG_VERTEX_COUNT) begin
          vertex_cnt = cfg_mon.data.wdata[VC_W-1:0];
        end else begin
          edge_cnt = cfg_mon.data.wdata[EC_W-1:0];
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(pull_step(in_mon.data));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t check: unexpected word, expected none, got %0b %0b %0b",
                   $time, out_mon.data.newly_active, out_mon.data.visited_now,
                   out_mon.data.status);
        end else begin
          want = expected_results.pop_front();
          if (out_mon.data !== want) begin
            mismatches++;
            $display("%0t check: expected %0b %0b %0b, got %0b %0b %0b",
                     $time, want.newly_active, want.visited_now, want.status,
                     out_mon.data.newly_active, out_mon.data.visited_now,
                     out_mon.data.status);
          end
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bfsp_pkg::*;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_EDGES    = 4096;
  localparam int unsigned RANDOM_WORDS = 1350;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bfsp_in_if  in_bus ();
  bfsp_out_if out_bus ();
  bfsp_cfg_if cfg_bus ();

  int          fail_count;
  int          pending;
  int unsigned words_sent = 0;
  int unsigned quiet_from = 32'hFFFF_FFFF;
  bit          quiet      = 1'b0;
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;

  // what the tables hold, so process words never read an entry not yet loaded
  int unsigned offset_seen [MAX_VERTICES];
  bit          offset_set  [MAX_VERTICES];
  bit          nbr_set     [MAX_EDGES];
  int unsigned cur_vc = 0;
  int unsigned cur_ec = 0;

  always #5 clk_i = ~clk_i;

  bfs_pull_frontier_step #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  bfsp_checker #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_mon     (cfg_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : result_ready
    int unsigned stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && !quiet && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_e r, int unsigned v);
    cfg_word_t word;
    word.index = r;
    word.wdata = v[CFG_W-1:0];
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= word;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    if (r == REG_VERTEX_COUNT) begin
      cur_vc = v & 'h7FF;
    end else begin
      cur_ec = v & 'h1FFF;
    end
  endtask

  task automatic send_item(func_e f, int unsigned idx, int unsigned val, bit fb, bit vb);
    in_word_t    word;
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 13) : 0;
    word.func         = f;
    word.index        = idx[INDEX_W-1:0];
    word.value        = val[VALUE_W-1:0];
    word.frontier_bit = fb;
    word.visited_bit  = vb;
    if (gap > 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b1;
    in_bus.data  <= word;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    words_sent++;
    quiet = words_sent >= quiet_from;
    if (f == FUNC_LOAD_ROW && idx < MAX_VERTICES) begin
      offset_seen[idx] = val;
      offset_set[idx]  = 1'b1;
    end
    if (f == FUNC_LOAD_NB && idx < MAX_EDGES && val < MAX_VERTICES) begin
      nbr_set[idx] = 1'b1;
    end
  endtask

  // a vertex whose walk could touch an unloaded entry is swapped for one out of range
  task automatic send_process(int unsigned idx);
    int unsigned lo, hi, k;
    bit          safe;
    safe = 1'b1;
    if (cur_vc <= MAX_VERTICES && idx < cur_vc) begin
      if (!offset_set[idx] || (idx + 1 < cur_vc && !offset_set[idx + 1])) begin
        safe = 1'b0;
      end else begin
        lo = offset_seen[idx];
        hi = (idx + 1 < cur_vc) ? offset_seen[idx + 1] : cur_ec;
        if (lo <= hi && hi <= cur_ec && hi <= MAX_EDGES) begin
          for (k = lo; k < hi; k++) begin
            if (!nbr_set[k]) safe = 1'b0;
          end
        end
      end
    end
    if (!safe) idx = $urandom_range(cur_vc, 4095);
    send_item(FUNC_PROCESS, idx, $urandom_range(0, 8191), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise();
    func_e f;
    if ($urandom_range(0, 14) != 0) return;
    f = func_e'($urandom_range(0, 3));
    if (f == FUNC_PROCESS) begin
      send_process($urandom_range(0, 4095));
    end else begin
      send_item(f, $urandom_range(0, 4095), $urandom_range(0, 8191),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // load a small or large graph, then run two pull passes over its vertices
  task automatic run_graph_level();
    int unsigned n, base, total, mode, vc, ec, k, r, val, bad_k;
    int unsigned row_at [129];
    bit          big;
    // large graphs only while plenty of the run is left, so the word count lands near target
    big = (words_sent + 1000 < quiet_from + RANDOM_WORDS / 10) && ($urandom_range(0, 7) == 0);
    n = big ? $urandom_range(33, 120) : $urandom_range(1, 24);
    row_at[0] = 0;
    for (k = 0; k < n; k++) begin
      row_at[k + 1] = row_at[k] +
                      (($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 5));
    end
    total = row_at[n];
    base  = $urandom_range(0, MAX_EDGES - total);
    mode  = $urandom_range(0, 9);
    bad_k = $urandom_range(0, n - 1);
    vc    = n;
    ec    = base + total;
    case (mode)
      0: ec = ec + $urandom_range(1, 3);
      1: if (ec > 0) ec = ec - 1;
      2: vc = n + 1;
      3: vc = n - 1;
      4: vc = n | ($urandom_range(1, 3) << VC_W);
      default: ;
    endcase
    wait_idle();
    gap_pct   = 20 * $urandom_range(0, 2);
    stall_pct = 4 * $urandom_range(0, 2);
    write_reg(REG_VERTEX_COUNT, vc);
    write_reg(REG_EDGE_COUNT, ec);
    for (k = 0; k < n; k++) begin
      val = (mode == 5 && k == bad_k) ? $urandom_range(0, 8191) : base + row_at[k];
      send_item(FUNC_LOAD_ROW, k, val, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send_noise();
    end
    for (k = 0; k < total; k++) begin
      if ($urandom_range(0, 39) == 0) begin
        val = $urandom_range(MAX_VERTICES, 8191);
      end else if ($urandom_range(0, 19) == 0) begin
        val = $urandom_range(n, MAX_VERTICES - 1);
      end else begin
        val = $urandom_range(0, n - 1);
      end
      send_item(FUNC_LOAD_NB, base + k, val, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      send_noise();
    end
    for (r = 0; r < 2; r++) begin
      if (r == 0 || $urandom_range(0, 1)) begin
        for (k = 0; k < n; k++) begin
          send_item(FUNC_LOAD_FLAGS, k, $urandom_range(0, 8191),
                    $urandom_range(0, 99) < 35, $urandom_range(0, 99) < 15);
          send_noise();
        end
      end
      repeat (n + n / 2 + 1) begin
        send_process(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, n - 1));
        send_noise();
      end
    end
  endtask

  initial begin
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    gap_pct   = 20;
    stall_pct = 4;

    // empty graph, out of range loads and field extremes
    write_reg(REG_VERTEX_COUNT, 0);
    write_reg(REG_EDGE_COUNT, 0);
    send_item(FUNC_PROCESS, 0, 0, 1'b0, 1'b0);
    send_item(FUNC_PROCESS, 4095, 8191, 1'b1, 1'b1);
    send_item(FUNC_LOAD_ROW, 4095, 8191, 1'b1, 1'b1);
    send_item(FUNC_LOAD_NB, 4095, MAX_VERTICES, 1'b0, 1'b0);
    send_item(FUNC_LOAD_NB, 0, MAX_VERTICES - 1, 1'b1, 1'b0);
    send_item(FUNC_LOAD_FLAGS, MAX_VERTICES, 0, 1'b1, 1'b1);
    send_item(FUNC_LOAD_ROW, 0, 0, 1'b0, 1'b1);

    // full size: last vertex ends at the last edge, hit on its final neighbor
    wait_idle();
    write_reg(REG_VERTEX_COUNT, MAX_VERTICES);
    write_reg(REG_EDGE_COUNT, MAX_EDGES);
    send_item(FUNC_LOAD_FLAGS, MAX_VERTICES - 1, 0, 1'b0, 1'b1);
    send_item(FUNC_LOAD_ROW, MAX_VERTICES - 1, MAX_EDGES - 4, 1'b0, 1'b0);
    send_item(FUNC_PROCESS, MAX_VERTICES - 1, 0, 1'b0, 1'b0);
    send_item(FUNC_LOAD_FLAGS, MAX_VERTICES - 1, 0, 1'b1, 1'b0);
    send_item(FUNC_LOAD_NB, MAX_EDGES - 4, 1, 1'b0, 1'b0);
    send_item(FUNC_LOAD_NB, MAX_EDGES - 3, 2, 1'b0, 1'b0);
    send_item(FUNC_LOAD_NB, MAX_EDGES - 2, 0, 1'b0, 1'b0);
    send_item(FUNC_LOAD_NB, MAX_EDGES - 1, 3, 1'b0, 1'b0);
    send_item(FUNC_LOAD_FLAGS, 3, 0, 1'b1, 1'b0);
    send_item(FUNC_PROCESS, MAX_VERTICES - 1, 0, 1'b0, 1'b0);
    send_item(FUNC_PROCESS, MAX_VERTICES - 1, 0, 1'b0, 1'b0);

    // vertex count beyond the table size
    wait_idle();
    write_reg(REG_VERTEX_COUNT, 2047);
    write_reg(REG_EDGE_COUNT, 8191);
    send_item(FUNC_PROCESS, 0, 0, 1'b0, 1'b0);

    // bad neighbor, reversed edge range, empty list on the last vertex
    wait_idle();
    write_reg(REG_VERTEX_COUNT, 4);
    write_reg(REG_EDGE_COUNT, 1);
    send_item(FUNC_LOAD_ROW, 1, 1, 1'b0, 1'b0);
    send_item(FUNC_LOAD_ROW, 2, 0, 1'b0, 1'b0);
    send_item(FUNC_LOAD_ROW, 3, 1, 1'b0, 1'b0);
    send_item(FUNC_PROCESS, 0, 0, 1'b0, 1'b0);
    send_item(FUNC_PROCESS, 1, 0, 1'b0, 1'b0);
    send_item(FUNC_PROCESS, 3, 0, 1'b0, 1'b0);

    quiet_from = words_sent + RANDOM_WORDS * 9 / 10;
    while (words_sent < quiet_from + RANDOM_WORDS / 10) begin
      run_graph_level();
    end

    wait_idle();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
